// ===== hw/rtl/sha256_pkg.sv =====
// Shared types and constants for the SHA-256 byte stream hasher.
package sha256_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int BLOCK_BITS  = BLOCK_BYTES * 8;
  localparam int BLOCK_WORDS = 16;
  localparam int ROUNDS      = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [5:0] LAST_BYTE_POS = 6'd63;
  localparam logic [5:0] LENGTH_SLOT   = 6'd56;
  localparam logic [7:0] PAD_MARK      = 8'h80;
  localparam logic [5:0] LAST_ROUND    = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;
  localparam logic [2:0] LAST_LEN_BYTE = 3'd7;

  // Item classes seen by the back end.
  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } q_entry_t;

  // Commands from the padding sequencer to the compression engine.
  typedef struct packed {
    logic                        load;
    logic                        digest;
    logic [BLOCK_WORDS-1:0][31:0] block;
  } eng_cmd_t;

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

// ===== hw/rtl/sha256_front.sv =====
// Input front end: classifies items and queues them for the back end.
module sha256_front
  import sha256_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_data_byte,
  output logic       q_valid,
  output q_entry_t   q_entry,
  input  logic       q_pop
);

  q_entry_t   mem_r [QUEUE_DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       push;
  logic       pop;
  q_entry_t   new_entry;

  assign in_ready = (count_r != 3'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 3'd0);
  assign pop      = q_pop && q_valid;
  assign q_entry  = mem_r[rd_ptr_r];

  always_comb begin
    new_entry.op   = in_kind ? OP_FINISH : OP_ABSORB;
    new_entry.data = in_data_byte;
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 2'd1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 2'd1 : rd_ptr_r;
    count_nxt  = count_r + {2'd0, push} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_entry;
    end
  end

endmodule

// ===== hw/rtl/sha256_pad.sv =====
// Block assembly and padding sequencer: collects bytes into 64-byte blocks.
module sha256_pad
  import sha256_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  q_entry_t q_entry,
  output logic     q_pop,
  input  logic     eng_ready,
  output eng_cmd_t eng_cmd
);

  typedef enum logic [4:0] {
    ST_DATA = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_ZERO = 5'b00100,
    ST_LEN  = 5'b01000,
    ST_WAIT = 5'b10000
  } pad_state_t;

  pad_state_t            st_r, st_nxt;
  logic [5:0]            fill_r, fill_nxt;
  logic [BLOCK_BITS-1:0] col_r, col_nxt;
  logic [63:0]           cnt_r, cnt_nxt;
  logic [63:0]           len_r, len_nxt;
  logic [2:0]            lcnt_r, lcnt_nxt;
  logic                  can_push;
  logic                  push;
  logic [7:0]            push_byte;
  logic                  digest;

  // Last byte of a block may go in only when the engine can take the block.
  assign can_push = (fill_r != LAST_BYTE_POS) || eng_ready;

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    lcnt_nxt  = lcnt_r;
    q_pop     = 1'b0;
    push      = 1'b0;
    push_byte = '0;
    digest    = 1'b0;
    unique case (st_r)
      ST_DATA: begin
        if (q_valid) begin
          if (q_entry.op == OP_ABSORB) begin
            if (can_push) begin
              push      = 1'b1;
              push_byte = q_entry.data;
              q_pop     = 1'b1;
              cnt_nxt   = cnt_r + 64'd1;
            end
          end else begin
            q_pop   = 1'b1;
            len_nxt = {cnt_r[60:0], 3'b000};
            cnt_nxt = '0;
            st_nxt  = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (can_push) begin
          push      = 1'b1;
          push_byte = PAD_MARK;
          st_nxt    = ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (fill_r == LENGTH_SLOT) begin
          lcnt_nxt = '0;
          st_nxt   = ST_LEN;
        end else if (can_push) begin
          push = 1'b1;
        end
      end
      ST_LEN: begin
        if (can_push) begin
          push      = 1'b1;
          push_byte = len_r[63:56];
          len_nxt   = {len_r[55:0], 8'h00};
          lcnt_nxt  = lcnt_r + 3'd1;
          if (lcnt_r == LAST_LEN_BYTE) begin
            st_nxt = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (eng_ready) begin
          digest = 1'b1;
          st_nxt = ST_DATA;
        end
      end
      default: st_nxt = ST_DATA;
    endcase
  end

  always_comb begin
    fill_nxt = push ? fill_r + 6'd1 : fill_r;
    col_nxt  = push ? {col_r[BLOCK_BITS-9:0], push_byte} : col_r;
  end

  always_comb begin
    eng_cmd.load   = push && (fill_r == LAST_BYTE_POS);
    eng_cmd.digest = digest;
    eng_cmd.block  = {col_r[BLOCK_BITS-9:0], push_byte};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_DATA;
      fill_r <= '0;
      cnt_r  <= '0;
      lcnt_r <= '0;
    end else begin
      st_r   <= st_nxt;
      fill_r <= fill_nxt;
      cnt_r  <= cnt_nxt;
      lcnt_r <= lcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
    len_r <= len_nxt;
  end

endmodule

// ===== hw/rtl/sha256_round.sv =====
// Compression engine: one SHA-256 round per cycle, hash state, digest output.
module sha256_round
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  eng_cmd_t    eng_cmd,
  output logic        eng_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  typedef enum logic [3:0] {
    E_IDLE = 4'b0001,
    E_RUN  = 4'b0010,
    E_ADD  = 4'b0100,
    E_EMIT = 4'b1000
  } eng_state_t;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  eng_state_t                    st_r, st_nxt;
  logic [7:0][31:0]              h_r, h_nxt;
  logic [7:0][31:0]              v_r, v_nxt;
  logic [BLOCK_WORDS-1:0][31:0]  w_r, w_nxt;
  logic [5:0]                    rnd_r, rnd_nxt;
  logic [2:0]                    widx_r, widx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [31:0]                   out_word_r, out_word_nxt;
  logic [2:0]                    out_idx_r, out_idx_nxt;
  logic                          out_last_r, out_last_nxt;
  logic [31:0]                   big0, big1, choose, major, t1, t2;
  logic [31:0]                   sig0, sig1, w_next;

  assign eng_ready       = (st_r == E_IDLE);
  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_last_r;

  // Round datapath and message schedule.
  always_comb begin
    big1   = ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25);
    choose = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1     = v_r[7] + big1 + choose + ROUND_K[rnd_r] + w_r[0];
    big0   = ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22);
    major  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2     = big0 + major;
    sig0   = ror(w_r[1], 7) ^ ror(w_r[1], 18) ^ (w_r[1] >> 3);
    sig1   = ror(w_r[14], 17) ^ ror(w_r[14], 19) ^ (w_r[14] >> 10);
    w_next = w_r[0] + sig0 + w_r[9] + sig1;
  end

  always_comb begin
    st_nxt        = st_r;
    h_nxt         = h_r;
    v_nxt         = v_r;
    w_nxt         = w_r;
    rnd_nxt       = rnd_r;
    widx_nxt      = widx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    unique case (st_r)
      E_IDLE: begin
        if (eng_cmd.load) begin
          for (int i = 0; i < BLOCK_WORDS; i++) begin
            w_nxt[i] = eng_cmd.block[BLOCK_WORDS-1-i];
          end
          v_nxt   = h_r;
          rnd_nxt = '0;
          st_nxt  = E_RUN;
        end else if (eng_cmd.digest) begin
          widx_nxt = '0;
          st_nxt   = E_EMIT;
        end
      end
      E_RUN: begin
        for (int i = 7; i > 0; i--) begin
          v_nxt[i] = v_r[i-1];
        end
        v_nxt[4] = v_r[3] + t1;
        v_nxt[0] = t1 + t2;
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[BLOCK_WORDS-1] = w_next;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == LAST_ROUND) begin
          st_nxt = E_ADD;
        end
      end
      E_ADD: begin
        for (int i = 0; i < 8; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        st_nxt = E_IDLE;
      end
      E_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = h_r[widx_r];
          out_idx_nxt   = widx_r;
          out_last_nxt  = (widx_r == LAST_WORD_IDX);
          widx_nxt      = widx_r + 3'd1;
          if (widx_r == LAST_WORD_IDX) begin
            // Digest is out of the hash registers: start the next message.
            for (int i = 0; i < 8; i++) begin
              h_nxt[i] = HASH_IV[i];
            end
            st_nxt = E_IDLE;
          end
        end
      end
      default: st_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= E_IDLE;
      rnd_r       <= '0;
      widx_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= HASH_IV[i];
      end
    end else begin
      st_r        <= st_nxt;
      rnd_r       <= rnd_nxt;
      widx_r      <= widx_nxt;
      out_valid_r <= out_valid_nxt;
      h_r         <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    w_r        <= w_nxt;
    out_word_r <= out_word_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

// ===== hw/rtl/sha256_byte_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher.
//
//  Channel  Direction  Transfer when          Payload
//  in_      input      in_valid & in_ready    in_kind, in_data_byte
//  out_     output     out_valid & out_ready  out_digest_word, out_word_index,
//                                             out_last_word
//
// Absorb bytes stream at one per cycle while the engine can take blocks; a
// block runs 64 rounds plus an add step in the compression engine before
// the engine is back to idle, and the last byte of the next block stalls
// until then.
// A finish transfer is padded one byte per cycle, under the same stalls,
// through the same block collector (up to 72 bytes), needs one or two
// compressions, then eight digest words leave via a registered output stage.
// Reset (rst_n low, synchronous) empties the queue and loads the initial
// hash values. A four-entry queue lets input transfers continue while the
// back end pads, compresses or waits on out_ready.
module sha256_byte_stream_hasher
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  logic     q_valid;
  q_entry_t q_entry;
  logic     q_pop;
  logic     eng_ready;
  eng_cmd_t eng_cmd;

  // Front: accept and classify, queue for the back end.
  sha256_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_data_byte (in_data_byte),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop)
  );

  // Back: block assembly, padding and length trailer.
  sha256_pad u_pad (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .eng_ready (eng_ready),
    .eng_cmd   (eng_cmd)
  );

  // Back: compression rounds, hash state and digest output.
  sha256_round u_round (
    .clk             (clk),
    .rst_n           (rst_n),
    .eng_cmd         (eng_cmd),
    .eng_ready       (eng_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  // A block is handed over only when the engine is idle.
  a_load_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    eng_cmd.load |-> eng_ready)
    else $error("block load while compression engine busy");

  // Block load and digest request never coincide.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(eng_cmd.load && eng_cmd.digest))
    else $error("load and digest requested together");

  // Last-word flag marks exactly the final digest word.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == LAST_WORD_IDX)))
    else $error("last_word flag does not match word index");

  // Once the engine starts a block, it is busy on the next cycle.
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    eng_cmd.load |=> !eng_ready)
    else $error("engine idle right after block load");

endmodule

// ===== tb/tb_sha256_byte_stream_hasher.sv =====
// Self-checking testbench for the SHA-256 byte stream hasher against a digest predictor.
module tb_sha256_byte_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  import sha256_pkg::*;

  // ---------------------------------------------------------------------------
  // Run knobs
  // ---------------------------------------------------------------------------
  localparam int          CLK_HALF      = 2;       // 4 ns period
  localparam int          RESET_CYCLES  = 6;
  localparam int          IDLE_PCT      = 36;      // idle / stall rate per side
  localparam int unsigned QUIET_FROM    = 1500;    // no idling on either side
  localparam int unsigned QUIET_TO      = 3000;    //   between these cycles
  localparam int          STREAM_ITEMS  = 310;     // input transfers to aim for
  localparam int          MIN_DIGESTS   = 10;      // keep going until this many
  localparam int          DRAIN_CYCLES  = 300;     // covers padding, two compressions and digest out
  localparam int unsigned CYCLE_LIMIT   = 200000;

  localparam logic [7:0]  PAD_BYTE      = 8'h80;
  localparam int          LEN_OFFSET    = 56;      // where the bit length goes

  // Message lengths around the padding and block boundaries.
  localparam int unsigned EDGE_LENGTHS [14] = '{
    0, 1, 54, 55, 56, 57, 62, 63, 64, 65, 119, 120, 127, 128};

  // Round constants and initial hash, kept locally so the RTL tables get checked.
  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  typedef struct packed {
    op_t        kind;
    logic [7:0] data;
  } stream_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input known from time zero
  // ---------------------------------------------------------------------------
  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic        in_kind      = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_byte_stream_hasher dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Reset once, at the start only.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
  end

  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // Queues and counters
  // ---------------------------------------------------------------------------
  stream_item_t send_q[$];      // items waiting for the driver
  digest_word_t digest_q[$];    // digest words predicted, not yet seen
  stream_item_t drv_item;
  int           item_total   = 0;
  int           digest_total = 0;
  int           errors       = 0;

  // ---------------------------------------------------------------------------
  // Digest predictor: running hash, partial block, byte count
  // ---------------------------------------------------------------------------
  logic [31:0] hash_state [8];
  logic [7:0]  block_buf [64];
  int          buf_fill;
  logic [63:0] msg_bytes;        // wraps mod 2^64 like the hardware counter

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic start_digest();
    for (int i = 0; i < 8; i++) hash_state[i] = SHA_IV[i];
    buf_fill  = 0;
    msg_bytes = '0;
  endtask

  // One 64-round compression of block_buf into hash_state.
  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3))
           + w[t-7] + (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10));
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + SHA_K[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic absorb_byte(input logic [7:0] data);
    block_buf[buf_fill] = data;
    buf_fill  = buf_fill + 1;
    msg_bytes = msg_bytes + 64'd1;
    if (buf_fill == 64) begin
      compress_block();
      buf_fill = 0;
    end
  endtask

  // Pad, append the bit length, compress, queue the eight words, restart.
  task automatic close_message();
    logic [63:0]  bit_len;
    digest_word_t dw;
    bit_len = msg_bytes << 3;
    block_buf[buf_fill] = PAD_BYTE;
    buf_fill = buf_fill + 1;
    // no room for the length: pad out and spend an extra block
    if (buf_fill > LEN_OFFSET) begin
      while (buf_fill < 64) begin
        block_buf[buf_fill] = 8'h00;
        buf_fill = buf_fill + 1;
      end
      compress_block();
      buf_fill = 0;
    end
    while (buf_fill < LEN_OFFSET) begin
      block_buf[buf_fill] = 8'h00;
      buf_fill = buf_fill + 1;
    end
    for (int i = 0; i < 8; i++) block_buf[LEN_OFFSET + i] = bit_len[63 - 8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      dw.word  = hash_state[i];
      dw.index = i[2:0];
      dw.last  = (i == 7);
      digest_q.push_back(dw);
    end
    start_digest();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] data);
    stream_item_t it;
    it.kind = OP_ABSORB;
    it.data = data;
    send_q.push_back(it);
    item_total++;
  endtask

  // data_byte rides along on a finish and must be ignored
  task automatic push_finish(input logic [7:0] noise);
    stream_item_t it;
    it.kind = OP_FINISH;
    it.data = noise;
    send_q.push_back(it);
    item_total++;
    digest_total++;
  endtask

  // flat: every byte the same value, else random bytes
  task automatic push_message(input int unsigned len, input bit flat);
    logic [7:0] fill;
    fill = 8'($urandom_range(0, 255));
    for (int unsigned i = 0; i < len; i++)
      push_byte(flat ? fill : 8'($urandom_range(0, 255)));
    push_finish(8'($urandom_range(0, 255)));
  endtask

  // Idle/stall pick shared by both sides; off inside the quiet window.
  function automatic bit idle_pick();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: next item only after the current transfer (or while idle)
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (send_q.size() != 0 && !idle_pick()) begin
        drv_item = send_q.pop_front();
        in_valid     <= 1'b1;
        in_kind      <= drv_item.kind;
        in_data_byte <= drv_item.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_pick();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input transfers, check on output transfers.
  // Both sampled at the same edge, before the driver's updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    digest_word_t want;
    if (!rst_n) begin
      start_digest();
    end else begin
      if (in_valid && in_ready) begin
        if (op_t'(in_kind) == OP_FINISH) begin
          close_message();
        end else begin
          absorb_byte(in_data_byte);
        end
      end
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $display("%0t unexpected digest transfer: expected none actual %h idx %0d last %0b",
                   $time, out_digest_word, out_word_index, out_last_word);
          errors++;
        end else begin
          want = digest_q.pop_front();
          if (out_digest_word !== want.word) begin
            $display("%0t digest_word mismatch: expected %h actual %h",
                     $time, want.word, out_digest_word);
            errors++;
          end
          if (out_word_index !== want.index) begin
            $display("%0t word_index mismatch: expected %0d actual %0d",
                     $time, want.index, out_word_index);
            errors++;
          end
          if (out_last_word !== want.last) begin
            $display("%0t last_word mismatch: expected %0b actual %0b",
                     $time, want.last, out_last_word);
            errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned len;

    // Directed: empty message, "abc", byte extremes, pad-mark byte as data.
    push_finish(8'hff);
    push_byte(8'h61); push_byte(8'h62); push_byte(8'h63);
    push_finish(8'h00);
    push_byte(8'h00);
    push_finish(8'h5a);
    push_byte(8'hff);
    push_finish(8'hff);
    push_byte(8'h80); push_byte(8'h7f); push_byte(8'h55); push_byte(8'haa);
    push_finish(8'h01);

    // Random messages; a good share sit on the padding/block boundaries.
    while (item_total < STREAM_ITEMS || digest_total < MIN_DIGESTS) begin
      if ($urandom_range(0, 99) < 45) begin
        len = EDGE_LENGTHS[$urandom_range(0, 13)];
      end else begin
        len = $urandom_range(0, 30);
      end
      push_message(len, $urandom_range(0, 9) == 0);
    end

    // Unterminated tail: absorbed, never finished, must yield nothing.
    for (int i = 0; i < 5; i++) push_byte(8'($urandom_range(0, 255)));

    while (send_q.size() != 0 || in_valid) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && digest_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_front.sv
hw/rtl/sha256_pad.sv
hw/rtl/sha256_round.sv
hw/rtl/sha256_byte_stream_hasher.sv
tb/tb_sha256_byte_stream_hasher.sv
